>>> src/sitda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

	// character width and the codes that the block emits
	localparam int unsigned CHAR_W = 8;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic skip_digit;
		logic emit_sign;
		logic emit_digit;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic conv_last;
		logic top_zero;
		logic dig_one;
		logic neg;
	} ctrl_sts_t;

endpackage
`default_nettype wire

>>> src/sitda_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_ctrl
// Sequencer: load, bit-serial conversion, leading zero skip, character output.
// ----------------------------------------------------------------------------
module sitda_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  sitda_pkg::ctrl_sts_t   sts,
	output sitda_pkg::ctrl_cmd_t   cmd,
	output logic                   busy
);
	import sitda_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (sts.conv_last) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, keep at least one digit
				if (sts.top_zero && !sts.dig_one) begin
					cmd.skip_digit = 1'b1;
				end else if (sts.neg) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				cmd.emit_sign = 1'b1;
				state_d       = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_digit = 1'b1;
				if (sts.dig_one) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> src/sitda_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_dp
// Datapath: magnitude, shift-add-3 BCD register, counters, output register.
// ----------------------------------------------------------------------------
module sitda_dp #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	input  sitda_pkg::ctrl_cmd_t             cmd,
	output sitda_pkg::ctrl_sts_t             sts,
	output logic [sitda_pkg::CHAR_W-1:0]     char_code,
	output logic                             last_char,
	output logic                             char_valid
);
	import sitda_pkg::*;

	// decimal digits needed for a VALUE_WIDTH-bit magnitude
	localparam int unsigned NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int unsigned BW   = 4 * NDIG;
	localparam int unsigned CW   = $clog2(VALUE_WIDTH + 1);
	localparam int unsigned DW   = $clog2(NDIG + 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          bcd_adj;
	logic [CW-1:0]          bit_cnt_q;
	logic [DW-1:0]          dig_cnt_q;
	logic                   neg_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   valid_q;
	logic [3:0]             top_nib;
	logic                   in_neg;

	assign in_neg  = value[VALUE_WIDTH-1];
	assign top_nib = bcd_q[BW-1 -: 4];

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		logic [3:0] nib;
		nib     = '0;
		bcd_adj = '0;
		for (int i = 0; i < NDIG; i++) begin
			nib = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
		end
	end

	// conversion registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q     <= in_neg ? (~value + VALUE_WIDTH'(1)) : value;
			neg_q     <= in_neg;
			bcd_q     <= '0;
			bit_cnt_q <= CW'(VALUE_WIDTH);
			dig_cnt_q <= DW'(NDIG);
		end else if (cmd.conv_step) begin
			bcd_q     <= {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q - CW'(1);
		end else if (cmd.skip_digit || cmd.emit_digit) begin
			bcd_q     <= {bcd_q[BW-5:0], 4'd0};
			dig_cnt_q <= dig_cnt_q - DW'(1);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.emit_sign) begin
			char_q <= ASCII_MINUS;
			last_q <= 1'b0;
		end else if (cmd.emit_digit) begin
			char_q <= ASCII_ZERO + CHAR_W'(top_nib);
			last_q <= (dig_cnt_q == DW'(1));
		end
	end

	// output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit_sign || cmd.emit_digit;
		end
	end

	// status to controller
	always_comb begin
		sts.conv_last = (bit_cnt_q == CW'(1));
		sts.top_zero  = (top_nib == 4'd0);
		sts.dig_one   = (dig_cnt_q == DW'(1));
		sts.neg       = neg_q;
	end

	assign char_code  = char_q;
	assign last_char  = last_q;
	assign char_valid = valid_q;

	// strobe is registered: it rises in the cycle after an emit command
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit) |=> char_valid)
		else $error("missing character strobe");

	a_no_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_sign || cmd.emit_digit) |=> !char_valid)
		else $error("spurious character strobe");

	// sign character is never the last one
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_sign |=> (char_code == ASCII_MINUS) && !last_char)
		else $error("bad sign character");

	// emitted digits are valid decimal digits
	a_digit: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.emit_digit) && char_valid |->
			(char_code >= ASCII_ZERO) && (char_code <= ASCII_ZERO + 8'd9))
		else $error("digit out of range");

endmodule
`default_nettype wire

>>> src/signed_int_to_decimal_ascii.sv
`default_nettype none
// Sequence: bit-serial conversion of every magnitude bit, then a skip step per leading zero dropped
// and a final check, then one character per cycle ('-' first if negative); each strobe is registered.
// One value at a time: start is taken only while busy is low, after the last digit has been emitted;
// the pace is set by the bit-serial shift-add-3 loop and the one-digit-a-cycle skip and output.
// Reset clears the sequencer and the strobe; the output never stalls.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, most significant first.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic signed [VALUE_WIDTH-1:0] value,
	output logic [sitda_pkg::CHAR_W-1:0]       char_code,
	output logic                               last_char,
	output logic                               char_valid
);
	import sitda_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	// sequencer
	sitda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// conversion datapath
	sitda_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.char_code  (char_code),
		.last_char  (last_char),
		.char_valid (char_valid)
	);

endmodule
`default_nettype wire
